// ===== hdl/ovl_pkg.sv =====
// Shared types, constants and codes for the ordered value list.
package ovl_pkg;

    localparam int CAPACITY = 16;
    localparam int VALUE_W  = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OUT_W    = 5;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_FIND   = 2'd2;

    localparam logic [1:0] STS_OK   = 2'd0;
    localparam logic [1:0] STS_FULL = 2'd1;
    localparam logic [1:0] STS_MISS = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_COMMIT
    } ovl_state_t;

    typedef struct packed {
        logic compare_en;
        logic append_en;
        logic remove_en;
    } ovl_ctrl_t;

endpackage

// ===== hdl/ovl_cell.sv =====
// One list entry: holds a value, compares it with the key and shifts on remove.
module ovl_cell import ovl_pkg::*; (
    input  logic               aclk,
    input  ovl_ctrl_t          ctrl,
    input  logic [VALUE_W-1:0] key,
    input  logic [VALUE_W-1:0] next_entry,
    input  logic               occupied,
    input  logic               wr_sel,
    input  logic               hit_in,
    output logic [VALUE_W-1:0] entry,
    output logic               hit_out,
    output logic               first_hit
);

    logic [VALUE_W-1:0] entry_reg;
    logic               match_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.compare_en) begin
            match_reg <= occupied && (entry_reg == key);
        end
        if (ctrl.append_en && wr_sel) begin
            entry_reg <= key;
        end else if (ctrl.remove_en && hit_out) begin
            entry_reg <= next_entry;
        end
    end

    assign hit_out   = hit_in | match_reg;
    assign first_hit = match_reg & ~hit_in;
    assign entry     = entry_reg;

endmodule

// ===== hdl/ovl_chain.sv =====
// Row of entry cells with the match-prefix chain and first-match encoder.
module ovl_chain import ovl_pkg::*; (
    input  logic               aclk,
    input  ovl_ctrl_t          ctrl,
    input  logic [VALUE_W-1:0] key,
    input  logic [CNT_W-1:0]   count,
    output logic               any_hit,
    output logic [IDX_W-1:0]   hit_idx
);

    logic [VALUE_W-1:0] entry [CAPACITY];
    logic [CAPACITY:0]  hit;
    logic [CAPACITY-1:0] first_hit;

    assign hit[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [VALUE_W-1:0] next_entry;

        if (i == CAPACITY - 1) begin : g_last
            assign next_entry = key;
        end else begin : g_mid
            assign next_entry = entry[i+1];
        end

        ovl_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .key        (key),
            .next_entry (next_entry),
            .occupied   (CNT_W'(i) < count),
            .wr_sel     (count == CNT_W'(i)),
            .hit_in     (hit[i]),
            .entry      (entry[i]),
            .hit_out    (hit[i+1]),
            .first_hit  (first_hit[i])
        );
    end

    assign any_hit = hit[CAPACITY];

    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (first_hit[i]) begin
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
    end

endmodule

// ===== hdl/ordered_value_list.sv =====
// Top level of the ordered value list: command sequencer and result register.
//
// Keeps an insertion-ordered list of up to CAPACITY signed 32-bit values in a
// row of cells, one value per cell. Each command passes the idle, match and
// commit states: one in which the command beat is captured, one in which every
// cell compares its value with the key at once, and one in which the first match
// is encoded and the list is updated (append writes the cell at the count, remove
// shifts every cell from the first match on by one place). The result is
// registered as the commit state ends, and s_ready returns with it, so a new
// command is not taken before the last one is through. The result register holds
// one result, so a stalled m_ready holds the next command in its update cycle.
// Command code three does nothing and returns the unchanged count.
// first_index reads all ones when there is no match.
module ordered_value_list import ovl_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_cmd,
    input  logic signed [31:0] s_value,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_status,
    output logic              m_found,
    output logic signed [4:0] m_first_index,
    output logic [4:0]        m_entry_count
);

    ovl_state_t         state_reg, state_next;
    logic [1:0]         cmd_reg;
    logic [VALUE_W-1:0] key_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               m_valid_reg, m_valid_next;
    logic [1:0]         m_status_reg, m_status_next;
    logic               m_found_reg, m_found_next;
    logic [OUT_W-1:0]   m_index_reg, m_index_next;
    logic [OUT_W-1:0]   m_count_reg, m_count_next;

    ovl_ctrl_t          ctrl;
    logic               any_hit;
    logic [IDX_W-1:0]   hit_idx;
    logic               out_free;
    logic               load;

    ovl_chain u_chain (
        .aclk    (aclk),
        .ctrl    (ctrl),
        .key     (key_reg),
        .count   (count_reg),
        .any_hit (any_hit),
        .hit_idx (hit_idx)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg <= s_cmd;
            key_reg <= s_value;
        end
        if (load) begin
            m_status_reg <= m_status_next;
            m_found_reg  <= m_found_next;
            m_index_reg  <= m_index_next;
            m_count_reg  <= m_count_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        ctrl            = '0;
        load            = 1'b0;
        m_status_next   = STS_OK;
        m_found_next    = 1'b0;
        m_index_next    = '1;
        m_valid_next    = m_ready ? 1'b0 : m_valid_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH: begin
                ctrl.compare_en = 1'b1;
                state_next      = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (out_free) begin
                    load         = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    case (cmd_reg)
                        CMD_APPEND: begin
                            if (count_reg == CNT_W'(CAPACITY)) begin
                                m_status_next = STS_FULL;
                            end else begin
                                ctrl.append_en = 1'b1;
                                count_next     = count_reg + 1'b1;
                            end
                        end
                        CMD_REMOVE, CMD_FIND: begin
                            if (!any_hit) begin
                                m_status_next = STS_MISS;
                            end else begin
                                m_found_next = 1'b1;
                                m_index_next = OUT_W'(hit_idx);
                                if (cmd_reg == CMD_REMOVE) begin
                                    ctrl.remove_en = 1'b1;
                                    count_next     = count_reg - 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        m_count_next = OUT_W'(count_next);
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_found       = m_found_reg;
    assign m_first_index = m_index_reg;
    assign m_entry_count = m_count_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_remove_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.remove_en) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("remove hit did not decrement count");

    a_append_inc: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.append_en) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("append did not increment count");

    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_found_reg) |-> (m_status_reg == STS_OK))
        else $error("found result with non-ok status");

    a_no_shift_on_append: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctrl.append_en && ctrl.remove_en))
        else $error("append and remove in the same cycle");
`endif

endmodule
